>>> rtl/asip_pkg.sv
package asip_pkg;

  // Parse phases of one string.
  typedef enum logic [2:0] {
    PH_DONE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS
  } phase_t;

  // Whether digits were taken, and whether the value ran past its limit.
  typedef enum logic [1:0] {
    DS_NONE,
    DS_SOME,
    DS_OVER
  } digit_status_t;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Offsets that map letters onto digit values 10 and up.
  localparam logic [7:0] UP_LETTER_BIAS = CH_UP_A - 8'd10;
  localparam logic [7:0] LO_LETTER_BIAS = CH_LO_A - 8'd10;

  // Radix codes.
  localparam logic [5:0] RADIX_AUTO  = 6'd0;
  localparam logic [5:0] RADIX_OCT   = 6'd8;
  localparam logic [5:0] RADIX_DEC   = 6'd10;
  localparam logic [5:0] RADIX_HEX   = 6'd16;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  // Signed 32-bit limits as magnitudes.
  localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // Largest end offset that fits the result field.
  localparam logic [31:0] OFFSET_MAX = 32'd255;

endpackage

>>> rtl/ascii_to_signed_integer_parser_core.sv
// Streaming string-to-integer parser, one character per request.
// A terminating character's result is captured in the output register.
// Throughput: one character per cycle while s_tready is high; the multiply-accumulate and
// limit compare on the running value are combinational, and the output register frees s_tready.
// Reset (rst, synchronous, active high): the parser waits for a start character,
// the radix register returns to 10, and no result is pending.
module ascii_to_signed_integer_parser_core #(
  parameter int MAX_STRING_LEN = 255
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: number base.
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  // Input characters.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] string_start
  // Parsed results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] parsed_value, [39:32] end_offset
  output logic        m_tuser    // [0] range_error
);

  localparam int POS_W = $clog2(MAX_STRING_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LEN);

  // Registers.
  logic [5:0]                     radix_select;
  asip_pkg::phase_t               phase;
  logic                           negative_flag;
  logic [5:0]                     active_radix;
  logic [31:0]                    accumulator;
  asip_pkg::digit_status_t        digit_status;
  logic [POS_W-1:0]               char_position;

  asip_pkg::phase_t               phase_next;
  logic                           negative_flag_next;
  logic [5:0]                     active_radix_next;
  logic [31:0]                    accumulator_next;
  asip_pkg::digit_status_t        digit_status_next;

  // Values seen by the current character after a possible restart.
  logic                           accept;
  logic [7:0]                     ch;
  logic                           start;
  logic                           live;
  asip_pkg::phase_t               ph_cur;
  logic                           neg_cur;
  logic [5:0]                     rad_cur;
  logic [31:0]                    acc_cur;
  asip_pkg::digit_status_t        ds_cur;
  logic [POS_W-1:0]               pos_cur;

  // Character decode.
  logic                           is_space;
  logic                           is_sign;
  logic                           is_x;
  logic                           digit_ok;
  logic [5:0]                     digit;

  // Digit step.
  logic [5:0]                     rad_use;
  asip_pkg::digit_status_t        ds_use;
  logic [37:0]                    product;
  logic [37:0]                    limit;
  logic                           emit;

  // Result fields.
  logic [31:0]                    value;
  logic                           range_error;
  logic [7:0]                     end_offset;
  logic [31:0]                    pos_wide;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign ch       = s_tdata;
  assign start    = s_tuser;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_select <= asip_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      radix_select <= cfg_wdata;
    end
  end

  // Classify the incoming character.
  always_comb begin
    is_space = (ch == asip_pkg::CH_SPACE) ||
               (ch >= asip_pkg::CH_TAB && ch <= asip_pkg::CH_CR);
    is_sign  = (ch == asip_pkg::CH_PLUS) || (ch == asip_pkg::CH_MINUS);
    is_x     = (ch == asip_pkg::CH_UP_X) || (ch == asip_pkg::CH_LO_X);
    digit_ok = 1'b1;
    digit    = '0;
    if (ch >= asip_pkg::CH_ZERO && ch <= asip_pkg::CH_NINE) begin
      digit = 6'(ch - asip_pkg::CH_ZERO);
    end else if (ch >= asip_pkg::CH_UP_A && ch <= asip_pkg::CH_UP_Z) begin
      digit = 6'(ch - asip_pkg::UP_LETTER_BIAS);
    end else if (ch >= asip_pkg::CH_LO_A && ch <= asip_pkg::CH_LO_Z) begin
      digit = 6'(ch - asip_pkg::LO_LETTER_BIAS);
    end else begin
      digit_ok = 1'b0;
    end
  end

  // A start character restarts the parse from a clean state.
  always_comb begin
    ph_cur  = start ? asip_pkg::PH_LEAD : phase;
    neg_cur = start ? 1'b0 : negative_flag;
    rad_cur = start ? 6'd0 : active_radix;
    acc_cur = start ? 32'd0 : accumulator;
    ds_cur  = start ? asip_pkg::DS_NONE : digit_status;
    if (start) begin
      pos_cur = '0;
    end else if (char_position < POS_MAX) begin
      pos_cur = char_position + POS_W'(1);
    end else begin
      pos_cur = char_position;
    end
    live = start || (phase != asip_pkg::PH_DONE);
  end

  // Next state: phase walk, radix latch and digit accumulation.
  always_comb begin
    phase_next         = ph_cur;
    negative_flag_next = neg_cur;
    active_radix_next  = rad_cur;
    accumulator_next   = acc_cur;
    digit_status_next  = ds_cur;
    rad_use            = rad_cur;
    ds_use             = ds_cur;
    emit               = 1'b0;

    // Pick the base and status that the digit step sees.
    priority if (!live) begin
      phase_next = phase;
    end else if (ph_cur == asip_pkg::PH_LEAD && is_space) begin
      phase_next = asip_pkg::PH_LEAD;
    end else if (ph_cur == asip_pkg::PH_LEAD && is_sign) begin
      negative_flag_next = (ch == asip_pkg::CH_MINUS);
      phase_next         = asip_pkg::PH_SIGNED;
    end else if (ph_cur == asip_pkg::PH_LEAD || ph_cur == asip_pkg::PH_SIGNED) begin
      if ((radix_select == asip_pkg::RADIX_AUTO || radix_select == asip_pkg::RADIX_HEX) &&
          ch == asip_pkg::CH_ZERO) begin
        active_radix_next = (radix_select == asip_pkg::RADIX_AUTO) ?
                            asip_pkg::RADIX_OCT : asip_pkg::RADIX_HEX;
        phase_next        = asip_pkg::PH_ZERO;
      end else begin
        rad_use           = (radix_select == asip_pkg::RADIX_AUTO) ?
                            asip_pkg::RADIX_DEC : radix_select;
        active_radix_next = rad_use;
        phase_next        = asip_pkg::PH_DIGITS;
      end
    end else if (ph_cur == asip_pkg::PH_ZERO && is_x) begin
      active_radix_next = asip_pkg::RADIX_HEX;
      phase_next        = asip_pkg::PH_HEXPFX;
    end else if (ph_cur == asip_pkg::PH_ZERO) begin
      // The leading zero counts as a digit; the value is still zero.
      ds_use     = asip_pkg::DS_SOME;
      phase_next = asip_pkg::PH_DIGITS;
    end else begin
      phase_next = asip_pkg::PH_DIGITS;
    end

    product = 38'(acc_cur) * 38'(rad_use) + 38'(digit);
    limit   = neg_cur ? 38'(asip_pkg::NEG_LIMIT) : 38'(asip_pkg::POS_LIMIT);

    // Digit step: terminate on a non-digit, else accumulate with saturation.
    if (live && phase_next == asip_pkg::PH_DIGITS) begin
      digit_status_next = ds_use;
      if (!digit_ok || digit >= rad_use) begin
        emit       = 1'b1;
        phase_next = asip_pkg::PH_DONE;
      end else if (ds_use == asip_pkg::DS_OVER || product > limit) begin
        digit_status_next = asip_pkg::DS_OVER;
      end else begin
        accumulator_next  = product[31:0];
        digit_status_next = asip_pkg::DS_SOME;
      end
    end
  end

  // Result fields for a terminating character.
  always_comb begin
    range_error = (ds_use == asip_pkg::DS_OVER);
    if (range_error) begin
      value = neg_cur ? asip_pkg::NEG_LIMIT : asip_pkg::POS_LIMIT;
    end else begin
      value = neg_cur ? (32'd0 - acc_cur) : acc_cur;
    end
    pos_wide = (ds_use == asip_pkg::DS_NONE) ? 32'd0 : 32'(pos_cur);
    end_offset = (pos_wide > asip_pkg::OFFSET_MAX) ? 8'hFF : pos_wide[7:0];
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= asip_pkg::PH_DONE;
      negative_flag <= 1'b0;
      active_radix  <= '0;
      accumulator   <= '0;
      digit_status  <= asip_pkg::DS_NONE;
      char_position <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      negative_flag <= negative_flag_next;
      active_radix  <= active_radix_next;
      accumulator   <= accumulator_next;
      digit_status  <= digit_status_next;
      if (live) begin
        char_position <= pos_cur;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {end_offset, value};
      m_tuser <= range_error;
    end
  end

endmodule

>>> rtl/asip_checker.sv
module asip_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A saturated result carries one of the two signed limits.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[31:0] == 32'h7fff_ffff) || (m_tdata[31:0] == 32'h8000_0000))
    else $error("range error without a limit value");

  // No digit taken means a zero value and no range error.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:32] == 8'd0) |-> (m_tdata[31:0] == 32'd0) && !m_tuser)
    else $error("zero offset with nonzero result");

  // A new result follows an accepted character.
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without a request");

endmodule

bind ascii_to_signed_integer_parser_core asip_checker u_asip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_STRING_LEN = 255;
  localparam int NOT_A_DIGIT    = 99;
  localparam int STALL_LIMIT    = 400;

  // One parse result as it should leave the block.
  typedef struct {
    logic [31:0] value;
    logic        range_err;
    logic [7:0]  offset;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] char_code
  logic        s_tuser = 1'b0; // [0] string_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] parsed_value, [39:32] end_offset
  logic        m_tuser;        // [0] range_error

  // Parser state mirrored by the predictor.
  logic [5:0]              radix_sel;
  asip_pkg::phase_t        phase;
  logic                    neg_flag;
  logic [5:0]              base;
  logic [31:0]             acc;
  asip_pkg::digit_status_t status;
  int                      pos;

  parse_result_t pending_results[$];
  int            errors = 0;
  int            idle_cycles = 0;
  int            chars_sent = 0;
  logic [5:0]    cfg_radix = asip_pkg::RADIX_RESET;
  bit            no_idle = 1'b0;

  ascii_to_signed_integer_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Value of a character as a digit, or a value above every base.
  function automatic int char_weight(input logic [7:0] c);
    if (c >= asip_pkg::CH_ZERO && c <= asip_pkg::CH_NINE)
      return int'(c - asip_pkg::CH_ZERO);
    if (c >= asip_pkg::CH_UP_A && c <= asip_pkg::CH_UP_Z)
      return int'(c - asip_pkg::UP_LETTER_BIAS);
    if (c >= asip_pkg::CH_LO_A && c <= asip_pkg::CH_LO_Z)
      return int'(c - asip_pkg::LO_LETTER_BIAS);
    return NOT_A_DIGIT;
  endfunction

  // Multiply-accumulate one digit; the value sticks at its limit once it overflows.
  function automatic void take_digit(input int d);
    logic [63:0] sum;
    logic [31:0] limit;
    limit = neg_flag ? asip_pkg::NEG_LIMIT : asip_pkg::POS_LIMIT;
    sum = {32'd0, acc} * {58'd0, base} + 64'(d);
    if (status == asip_pkg::DS_OVER || sum > {32'd0, limit}) begin
      status = asip_pkg::DS_OVER;
    end else begin
      acc = sum[31:0];
      status = asip_pkg::DS_SOME;
    end
  endfunction

  // Advance the parse by one character; returns 1 when the character ends the number.
  function automatic bit parse_step(input logic [7:0] c, input logic first,
                                    output parse_result_t res);
    int w;
    res = '{32'd0, 1'b0, 8'd0};
    if (first) begin
      phase = asip_pkg::PH_LEAD;
      neg_flag = 1'b0;
      base = '0;
      acc = '0;
      status = asip_pkg::DS_NONE;
      pos = 0;
    end else begin
      if (phase == asip_pkg::PH_DONE) return 1'b0;
      if (pos < MAX_STRING_LEN) pos++;
    end

    // Leading blanks and an optional sign.
    if (phase == asip_pkg::PH_LEAD) begin
      if (c == asip_pkg::CH_SPACE || (c >= asip_pkg::CH_TAB && c <= asip_pkg::CH_CR))
        return 1'b0;
      if (c == asip_pkg::CH_MINUS || c == asip_pkg::CH_PLUS) begin
        neg_flag = (c == asip_pkg::CH_MINUS);
        phase = asip_pkg::PH_SIGNED;
        return 1'b0;
      end
      phase = asip_pkg::PH_SIGNED;
    end

    // The base is latched here, with a leading zero held back in auto and hex modes.
    if (phase == asip_pkg::PH_SIGNED) begin
      if ((radix_sel == asip_pkg::RADIX_AUTO || radix_sel == asip_pkg::RADIX_HEX) &&
          c == asip_pkg::CH_ZERO) begin
        base = (radix_sel == asip_pkg::RADIX_AUTO) ? asip_pkg::RADIX_OCT :
                                                     asip_pkg::RADIX_HEX;
        phase = asip_pkg::PH_ZERO;
        return 1'b0;
      end
      base = (radix_sel == asip_pkg::RADIX_AUTO) ? asip_pkg::RADIX_DEC : radix_sel;
    end else if (phase == asip_pkg::PH_ZERO) begin
      if (c == asip_pkg::CH_LO_X || c == asip_pkg::CH_UP_X) begin
        base = asip_pkg::RADIX_HEX;
        phase = asip_pkg::PH_HEXPFX;
        return 1'b0;
      end
      take_digit(0);
    end

    // Digit phase: the first character outside the base ends the number.
    phase = asip_pkg::PH_DIGITS;
    w = char_weight(c);
    if (w >= int'(base)) begin
      if (status == asip_pkg::DS_OVER)
        res.value = neg_flag ? asip_pkg::NEG_LIMIT : asip_pkg::POS_LIMIT;
      else res.value = neg_flag ? (32'd0 - acc) : acc;
      res.range_err = (status == asip_pkg::DS_OVER);
      res.offset = (status == asip_pkg::DS_NONE) ? 8'd0 : 8'(pos);
      phase = asip_pkg::PH_DONE;
      return 1'b1;
    end
    take_digit(w);
    return 1'b0;
  endfunction

  // Predict on every accepted request, check every accepted result, and watch for hangs.
  always @(posedge clk) begin
    parse_result_t want;
    parse_result_t fresh;
    if (rst) begin
      radix_sel = asip_pkg::RADIX_RESET;
      phase = asip_pkg::PH_DONE;
      neg_flag = 1'b0;
      base = '0;
      acc = '0;
      status = asip_pkg::DS_NONE;
      pos = 0;
      pending_results.delete();
      idle_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $error("result arrived with no request waiting on it");
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[31:0] !== want.value) begin
            errors++;
            $error("parsed_value: expected %0d, got %0d",
                   $signed(want.value), $signed(m_tdata[31:0]));
          end
          if (m_tuser !== want.range_err) begin
            errors++;
            $error("range_error: expected %0d, got %0d", want.range_err, m_tuser);
          end
          if (m_tdata[39:32] !== want.offset) begin
            errors++;
            $error("end_offset: expected %0d, got %0d", want.offset, m_tdata[39:32]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (parse_step(s_tdata, s_tuser, fresh)) pending_results.push_back(fresh);
      end
      if (cfg_we) radix_sel = cfg_wdata;

      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** ascii_to_signed_integer_parser_core: FAILED **");
        $finish;
      end
    end
  end

  // Result side: a random stall before each result is taken.
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(11);
      @(negedge clk);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Offer one character after a random gap and hold it until it is taken.
  task automatic send_char(input logic [7:0] c, input logic first);
    int gap;
    gap = no_idle ? 0 : $urandom_range(11);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = c;
    s_tuser = first;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit fresh = 1'b1);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fresh && i == 0);
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic settle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_radix(input logic [5:0] r);
    settle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = r;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_radix = r;
  endtask

  // Signs, blanks, stray characters and restarts in the reset base.
  task automatic test_signs_and_restart();
    send_char(asip_pkg::CH_UP_A, 1'b0);
    send_text(" -7");
    send_char(8'hFF, 1'b0);
    // A blank after the sign ends the parse with no digits.
    send_text("+ ");
    // The second start drops the unfinished number.
    send_text("42");
    send_text("9");
    send_char(8'h00, 1'b0);
  endtask

  // Hex prefix, octal fallback, base one, and a base change in the middle of a string.
  task automatic test_prefixes_and_bases();
    write_radix(asip_pkg::RADIX_AUTO);
    send_text("0xg");
    send_text("017");
    send_char(8'h00, 1'b0);
    write_radix(asip_pkg::RADIX_HEX);
    send_text("0f ");
    write_radix(6'd1);
    send_text("01");
    write_radix(asip_pkg::RADIX_DEC);
    send_text("12");
    write_radix(asip_pkg::RADIX_HEX);
    send_text("a", 1'b0);
  endtask

  // Exact signed limits, overflow both ways, and offsets past the saturation point.
  task automatic test_limits_and_long_strings();
    write_radix(asip_pkg::RADIX_DEC);
    send_text("2147483647");
    send_char(8'h00, 1'b0);
    send_text("-2147483648.");
    send_text("2147483648 ");
    send_text("-2147483649x");
    send_char(asip_pkg::CH_SPACE, 1'b1);
    repeat (260) send_char(asip_pkg::CH_SPACE, 1'b0);
    send_text("-12!", 1'b0);
    send_text("9");
    repeat (260) send_char(asip_pkg::CH_NINE, 1'b0);
    send_text(".", 1'b0);
  endtask

  // One string: mostly a well-formed number in the current base, sometimes noise.
  task automatic send_number_string();
    logic [7:0] text[$];
    logic [7:0] t;
    int eff;
    int alpha;
    int ndig;
    int v;
    if ($urandom_range(9) == 0) send_char(8'($urandom_range(255)), 1'b0);
    if ($urandom_range(6) == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2))
        text.push_back($urandom_range(3) == 0 ? asip_pkg::CH_SPACE :
                       asip_pkg::CH_TAB + 8'($urandom_range(4)));
      case ($urandom_range(2))
        0: text.push_back(asip_pkg::CH_MINUS);
        1: text.push_back(asip_pkg::CH_PLUS);
        default: ;
      endcase
      eff = (cfg_radix == asip_pkg::RADIX_AUTO) ? int'(asip_pkg::RADIX_DEC) :
                                                  int'(cfg_radix);
      if ((cfg_radix == asip_pkg::RADIX_AUTO || cfg_radix == asip_pkg::RADIX_HEX) &&
          $urandom_range(2) == 0) begin
        text.push_back(asip_pkg::CH_ZERO);
        eff = (cfg_radix == asip_pkg::RADIX_AUTO) ? int'(asip_pkg::RADIX_OCT) :
                                                    int'(asip_pkg::RADIX_HEX);
        if ($urandom_range(1)) begin
          text.push_back($urandom_range(1) ? asip_pkg::CH_LO_X : asip_pkg::CH_UP_X);
          eff = int'(asip_pkg::RADIX_HEX);
        end
      end
      alpha = (eff > 36) ? 36 : eff;
      // Now and then enough digits to run past the limit.
      ndig = ($urandom_range(7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
      repeat (ndig) begin
        v = $urandom_range(alpha - 1);
        if (v < 10) text.push_back(asip_pkg::CH_ZERO + 8'(v));
        else text.push_back(($urandom_range(1) ? asip_pkg::CH_UP_A : asip_pkg::CH_LO_A) +
                            8'(v - 10));
      end
      case ($urandom_range(7))
        0: text.push_back(8'h00);
        1: ; // left open, so the next start abandons it
        default: begin
          do t = 8'($urandom_range(255)); while (char_weight(t) < eff);
          text.push_back(t);
        end
      endcase
    end
    foreach (text[i]) send_char(text[i], i == 0);
    // Anything after the terminator is ignored until the next start.
    repeat ($urandom_range(2)) send_char(8'($urandom_range(255)), 1'b0);
  endtask

  // Random strings across a series of bases, extremes included.
  task automatic test_random_strings();
    logic [5:0] plan[$];
    int mark;
    plan = '{asip_pkg::RADIX_DEC, asip_pkg::RADIX_AUTO, asip_pkg::RADIX_HEX, 6'd2, 6'd36,
             asip_pkg::RADIX_OCT, 6'd1, 6'd63, 6'd37};
    plan.push_back(6'($urandom_range(63)));
    foreach (plan[p]) begin
      write_radix(plan[p]);
      no_idle = (p % 4 == 3);
      mark = chars_sent;
      while (chars_sent - mark < 20) send_number_string();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst = 1'b0;
    test_signs_and_restart();
    test_prefixes_and_bases();
    test_limits_and_long_strings();
    test_random_strings();
    settle();
    if (errors == 0) $display("** ascii_to_signed_integer_parser_core: PASSED **");
    else $display("** ascii_to_signed_integer_parser_core: FAILED **");
    $finish;
  end

endmodule
